/* src/rps_pkg.sv */
// ----------------------------------------------------------------------------
// rps_pkg: shared types and constants for the reflow profile sequencer
// Beat payload structs, configuration image, zone codes and register indexes.
// ----------------------------------------------------------------------------
package rps_pkg;

	// Field widths
	localparam int TEMP_BITS      = 12;
	localparam int SECONDS_BITS   = 10;
	localparam int PRESCALE_BITS  = 6;
	localparam int TPS_BITS       = 7;
	localparam int ZONE_BITS      = 3;
	localparam int LED_BITS       = 5;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 12;

	// Zone codes
	localparam logic [ZONE_BITS-1:0] ZONE_IDLE    = 3'd0;
	localparam logic [ZONE_BITS-1:0] ZONE_PREHEAT = 3'd1;
	localparam logic [ZONE_BITS-1:0] ZONE_SOAK    = 3'd2;
	localparam logic [ZONE_BITS-1:0] ZONE_REFLOW  = 3'd3;
	localparam logic [ZONE_BITS-1:0] ZONE_HOLD    = 3'd4;
	localparam logic [ZONE_BITS-1:0] ZONE_COOL    = 3'd5;

	// Zone indicator masks
	localparam logic [LED_BITS-1:0] LED_PREHEAT = 5'b00001;
	localparam logic [LED_BITS-1:0] LED_SOAK    = 5'b00010;
	localparam logic [LED_BITS-1:0] LED_REFLOW  = 5'b00100;
	localparam logic [LED_BITS-1:0] LED_COOL    = 5'b01000;
	localparam logic [LED_BITS-1:0] LED_DONE    = 5'b10000;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PREHEAT_THR = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SOAK_SECS   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_REFLOW_THR  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_SECS   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COOL_THR    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOGGLE_SECS = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TICKS_PER_S = 3'd6;

	// Prescaler range
	localparam logic [TPS_BITS-1:0]      TPS_MAX      = 7'd64;
	localparam logic [PRESCALE_BITS-1:0] PRESCALE_TOP = '1;
	localparam logic [SECONDS_BITS-1:0]  SECONDS_MAX  = '1;

	typedef struct packed {
		logic [TEMP_BITS-1:0] temperature;
		logic                 start_switch;
	} rps_in_t;

	typedef struct packed {
		logic                 heater_relay;
		logic [LED_BITS-1:0]  zone_leds;
		logic [ZONE_BITS-1:0] zone;
		logic                 profile_done;
	} rps_out_t;

	typedef struct packed {
		logic [TEMP_BITS-1:0]     preheat_threshold;
		logic [SECONDS_BITS-1:0]  soak_seconds;
		logic [TEMP_BITS-1:0]     reflow_threshold;
		logic [SECONDS_BITS-1:0]  hold_seconds;
		logic [TEMP_BITS-1:0]     cool_threshold;
		logic [SECONDS_BITS-1:0]  toggle_seconds;
		logic [PRESCALE_BITS-1:0] prescale_last;
	} rps_cfg_t;

endpackage

/* src/rps_cfg.sv */
// ----------------------------------------------------------------------------
// rps_cfg: configuration register file
// Holds the profile thresholds and durations; stores the tick prescaler as
// its clamped terminal count so the core compares directly.
// ----------------------------------------------------------------------------
module rps_cfg import rps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output rps_cfg_t                  cfg
);

	rps_cfg_t                 cfg_q;
	logic [TPS_BITS-1:0]      tps_raw;
	logic [TPS_BITS-1:0]      tps_less;
	logic [PRESCALE_BITS-1:0] last_d;

	// Clamp ticks per second to 1..64 and convert to terminal count
	assign tps_raw  = cfg_data[TPS_BITS-1:0];
	assign tps_less = tps_raw - TPS_BITS'(1);
	always_comb begin
		if (tps_raw == '0) begin
			last_d = '0;
		end else if (tps_raw > TPS_MAX) begin
			last_d = PRESCALE_TOP;
		end else begin
			last_d = tps_less[PRESCALE_BITS-1:0];
		end
	end

	// Write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preheat_threshold <= TEMP_BITS'(2048);
			cfg_q.soak_seconds      <= SECONDS_BITS'(90);
			cfg_q.reflow_threshold  <= TEMP_BITS'(3000);
			cfg_q.hold_seconds      <= SECONDS_BITS'(30);
			cfg_q.cool_threshold    <= TEMP_BITS'(1000);
			cfg_q.toggle_seconds    <= SECONDS_BITS'(10);
			cfg_q.prescale_last     <= PRESCALE_BITS'(19);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PREHEAT_THR: cfg_q.preheat_threshold <= cfg_data[TEMP_BITS-1:0];
				CFG_SOAK_SECS:   cfg_q.soak_seconds      <= cfg_data[SECONDS_BITS-1:0];
				CFG_REFLOW_THR:  cfg_q.reflow_threshold  <= cfg_data[TEMP_BITS-1:0];
				CFG_HOLD_SECS:   cfg_q.hold_seconds      <= cfg_data[SECONDS_BITS-1:0];
				CFG_COOL_THR:    cfg_q.cool_threshold    <= cfg_data[TEMP_BITS-1:0];
				CFG_TOGGLE_SECS: cfg_q.toggle_seconds    <= cfg_data[SECONDS_BITS-1:0];
				CFG_TICKS_PER_S: cfg_q.prescale_last     <= last_d;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/rps_core.sv */
// ----------------------------------------------------------------------------
// rps_core: profile state machine and seconds timer
// Computes one tick's update from the staged sample and commits it when the
// staged beat moves to the output register.
// ----------------------------------------------------------------------------
module rps_core import rps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  rps_in_t  item,
	input  rps_cfg_t cfg,
	output rps_out_t result
);

	logic [ZONE_BITS-1:0]     zone_q, zone_d;
	logic [PRESCALE_BITS-1:0] presc_q, presc_d;
	logic [SECONDS_BITS-1:0]  secs_q, secs_d;
	logic                     relay_q, relay_d;
	logic [LED_BITS-1:0]      leds_q, leds_d;
	logic                     sw_q;
	logic                     rise;
	logic                     restart;
	logic                     done;
	logic                     timing_zone;

	assign rise = item.start_switch & ~sw_q;
	assign timing_zone = (zone_q == ZONE_PREHEAT) || (zone_q == ZONE_SOAK) ||
		(zone_q == ZONE_REFLOW) || (zone_q == ZONE_HOLD);

	// Zone transitions
	always_comb begin
		zone_d  = zone_q;
		relay_d = relay_q;
		leds_d  = leds_q;
		restart = 1'b0;
		done    = 1'b0;
		unique case (zone_q)
			ZONE_PREHEAT: begin
				if (item.temperature > cfg.preheat_threshold) begin
					zone_d  = ZONE_SOAK;
					relay_d = 1'b0;
					leds_d  = leds_q | LED_SOAK;
					restart = 1'b1;
				end else if (secs_q >= cfg.toggle_seconds) begin
					relay_d = ~relay_q;
					restart = 1'b1;
				end
			end
			ZONE_SOAK: begin
				if (secs_q >= cfg.soak_seconds) begin
					zone_d  = ZONE_REFLOW;
					relay_d = 1'b1;
					leds_d  = leds_q | LED_REFLOW;
					restart = 1'b1;
				end
			end
			ZONE_REFLOW: begin
				if (item.temperature > cfg.reflow_threshold) begin
					zone_d  = ZONE_HOLD;
					relay_d = 1'b0;
					restart = 1'b1;
				end else if (secs_q >= cfg.toggle_seconds) begin
					relay_d = ~relay_q;
					restart = 1'b1;
				end
			end
			ZONE_HOLD: begin
				if (secs_q >= cfg.hold_seconds) begin
					zone_d  = ZONE_COOL;
					relay_d = 1'b0;
					leds_d  = leds_q | LED_COOL;
					restart = 1'b1;
				end
			end
			ZONE_COOL: begin
				if (item.temperature < cfg.cool_threshold) begin
					zone_d  = ZONE_IDLE;
					relay_d = 1'b0;
					leds_d  = leds_q | LED_DONE;
					done    = 1'b1;
					restart = 1'b1;
				end
			end
			default: begin
				// idle and unused codes: start on a rising switch edge
				zone_d = ZONE_IDLE;
				if (rise) begin
					zone_d  = ZONE_PREHEAT;
					relay_d = 1'b1;
					leds_d  = LED_PREHEAT;
					restart = 1'b1;
				end
			end
		endcase
	end

	// Prescaler and saturating seconds count
	always_comb begin
		presc_d = presc_q;
		secs_d  = secs_q;
		if (restart) begin
			presc_d = '0;
			secs_d  = '0;
		end else if (timing_zone) begin
			if (presc_q >= cfg.prescale_last) begin
				presc_d = '0;
				if (secs_q != SECONDS_MAX) begin
					secs_d = secs_q + SECONDS_BITS'(1);
				end
			end else begin
				presc_d = presc_q + PRESCALE_BITS'(1);
			end
		end
	end

	// Commit state on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q  <= ZONE_IDLE;
			presc_q <= '0;
			secs_q  <= '0;
			relay_q <= 1'b0;
			leds_q  <= '0;
			sw_q    <= 1'b0;
		end else if (fire) begin
			zone_q  <= zone_d;
			presc_q <= presc_d;
			secs_q  <= secs_d;
			relay_q <= relay_d;
			leds_q  <= leds_d;
			sw_q    <= item.start_switch;
		end
	end

	assign result.heater_relay = relay_d;
	assign result.zone_leds    = leds_d;
	assign result.zone         = zone_d;
	assign result.profile_done = done;

endmodule

/* src/reflow_profile_sequencer.sv */
// ----------------------------------------------------------------------------
// reflow_profile_sequencer: reflow oven profile controller
// Input register, per-tick profile update and output register.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one beat per timer tick: a temperature
//   sample and the start switch level. out_valid/out_stall/out_data return
//   one beat per input beat: heater relay, sticky zone LEDs, current zone
//   and the done pulse, all as they stand after that tick.
//   A beat moves on a rising edge where valid is high and stall is low.
//   Path: each result beat passes the input register, then the output
//   register. Throughput: one beat per cycle while the receiver does not
//   stall; the only path that limits it is the zone compare and seconds
//   counter update between the two registers.
//   When the receiver stalls, the result holds in the output register and
//   one more beat waits in the input register; in_stall rises only when
//   both are full.
//   Configuration (cfg_we/cfg_index/cfg_data) writes take effect on the
//   next edge; write only while no beats are in flight.
//   Reset clears the pipeline and returns to idle with the relay off and
//   all LEDs dark; registers return to their default profile.
// ----------------------------------------------------------------------------
module reflow_profile_sequencer import rps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  rps_in_t                   in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rps_out_t                  out_data,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	rps_cfg_t cfg;
	rps_in_t  item_s1;
	logic     valid_s1;
	rps_out_t result;
	rps_out_t result_s2;
	logic     valid_s2;
	logic     fire;

	// Advance the staged beat when the output register is free or draining
	assign fire     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	rps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Output register: load on fire, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the reflow profile sequencer
// Drives one tick beat per item with random gaps and a randomly stalling
// receiver, runs a tick-level oven model alongside the block and compares
// every result beat field by field. A short table of hand-picked ticks walks
// the whole profile first; random profiles under several register settings
// follow.
// ----------------------------------------------------------------------------
module tb import rps_pkg::*;;

	localparam int PHASES      = 6;
	localparam int CHOKE_PHASE = 4;
	localparam int DIR_ROWS    = 23;
	localparam logic [TEMP_BITS-1:0] TEMP_TOP = '1;

	// Register values per phase, columns in register index order; phase 0
	// is loaded in the middle of the directed table
	localparam logic [CFG_DATA_BITS-1:0] PROFILES [PHASES][7] = '{
		'{12'd100,  12'd0,    12'd200,  12'd1,    12'd50,   12'd0,    12'd0},
		'{12'd1500, 12'd3,    12'd3000, 12'd2,    12'd800,  12'd2,    12'd3},
		'{12'd0,    12'd0,    12'd4000, 12'd0,    12'd4095, 12'd1,    12'd64},
		'{12'd4095, 12'd1023, 12'd0,    12'd1023, 12'd0,    12'd1023, 12'd127},
		'{12'd2000, 12'd2,    12'd2500, 12'd3,    12'd1000, 12'd0,    12'd1},
		'{12'd2048, 12'd5,    12'd3000, 12'd4,    12'd1000, 12'd3,    12'd2}
	};
	localparam int PHASE_ITEMS [PHASES] = '{0, 200, 150, 80, 250, 250};

	typedef struct packed {
		logic [TEMP_BITS-1:0] temp;
		logic                 sw;
		logic                 reconf;
		logic                 typed;
		rps_out_t             want;
	} dir_row_t;

	localparam rps_out_t NO_WANT = '0;

	// Directed ticks: reset defaults first, then profile 0 from the reconf row
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{12'd0,    1'b0, 1'b0, 1'b1, '{1'b0, 5'b00000, ZONE_IDLE,    1'b0}},
		'{12'd4095, 1'b0, 1'b0, 1'b1, '{1'b0, 5'b00000, ZONE_IDLE,    1'b0}},
		'{12'd0,    1'b1, 1'b0, 1'b1, '{1'b1, 5'b00001, ZONE_PREHEAT, 1'b0}},
		'{12'd2048, 1'b1, 1'b0, 1'b0, NO_WANT},
		'{12'd2049, 1'b0, 1'b0, 1'b1, '{1'b0, 5'b00011, ZONE_SOAK,    1'b0}},
		'{12'd0,    1'b0, 1'b1, 1'b1, '{1'b1, 5'b00111, ZONE_REFLOW,  1'b0}},
		'{12'd200,  1'b0, 1'b0, 1'b1, '{1'b0, 5'b00111, ZONE_REFLOW,  1'b0}},
		'{12'd0,    1'b1, 1'b0, 1'b0, NO_WANT},
		'{12'd4095, 1'b0, 1'b0, 1'b1, '{1'b0, 5'b00111, ZONE_HOLD,    1'b0}},
		'{12'd0,    1'b1, 1'b0, 1'b0, NO_WANT},
		'{12'd0,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{12'd50,   1'b0, 1'b0, 1'b0, NO_WANT},
		'{12'd49,   1'b0, 1'b0, 1'b1, '{1'b0, 5'b11111, ZONE_IDLE,    1'b1}},
		'{12'd0,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{12'd0,    1'b1, 1'b0, 1'b1, '{1'b1, 5'b00001, ZONE_PREHEAT, 1'b0}},
		'{12'd4095, 1'b1, 1'b0, 1'b0, NO_WANT},
		'{12'd0,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{12'd201,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{12'd4095, 1'b1, 1'b0, 1'b0, NO_WANT},
		'{12'd0,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{12'd4095, 1'b0, 1'b0, 1'b0, NO_WANT},
		'{12'd0,    1'b1, 1'b0, 1'b0, NO_WANT},
		'{12'd0,    1'b0, 1'b0, 1'b0, NO_WANT}
	};

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	rps_in_t                   in_data   = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	rps_out_t                  out_data;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// Register shadow, reset values
	logic [TEMP_BITS-1:0]    thr_preheat = 12'd2048;
	logic [SECONDS_BITS-1:0] soak_len    = 10'd90;
	logic [TEMP_BITS-1:0]    thr_reflow  = 12'd3000;
	logic [SECONDS_BITS-1:0] hold_len    = 10'd30;
	logic [TEMP_BITS-1:0]    thr_cool    = 12'd1000;
	logic [SECONDS_BITS-1:0] toggle_len  = 10'd10;
	logic [TPS_BITS-1:0]     tps_reg     = 7'd20;

	// Oven model state
	logic [ZONE_BITS-1:0]     z_now  = ZONE_IDLE;
	logic [PRESCALE_BITS-1:0] ticks  = '0;
	logic [SECONDS_BITS-1:0]  secs   = '0;
	logic                     relay  = 1'b0;
	logic [LED_BITS-1:0]      leds   = '0;
	logic                     sw_prev = 1'b0;

	rps_out_t due_status [$];
	rps_out_t oldest;
	int       fails = 0;
	int       choke = 0;
	logic     burst = 1'b0;

	reflow_profile_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Enter a zone: set relay, add its LED, restart the seconds timer
	function automatic void zone_entry(input logic [ZONE_BITS-1:0] z, input logic on,
			input logic [LED_BITS-1:0] mark);
		z_now = z;
		relay = on;
		leds  = leds | mark;
		ticks = '0;
		secs  = '0;
	endfunction

	// Advance the oven model by one tick and return the status it shows
	function automatic rps_out_t oven_step(input rps_in_t d);
		rps_out_t r;
		logic     rise;
		logic     done;
		logic     restart;
		int       top;
		rise    = d.start_switch && !sw_prev;
		done    = 1'b0;
		restart = 1'b0;
		case (z_now)
			ZONE_PREHEAT: begin
				if (d.temperature > thr_preheat) begin
					zone_entry(ZONE_SOAK, 1'b0, LED_SOAK);
					restart = 1'b1;
				end else if (secs >= toggle_len) begin
					relay   = !relay;
					ticks   = '0;
					secs    = '0;
					restart = 1'b1;
				end
			end
			ZONE_SOAK: begin
				if (secs >= soak_len) begin
					zone_entry(ZONE_REFLOW, 1'b1, LED_REFLOW);
					restart = 1'b1;
				end
			end
			ZONE_REFLOW: begin
				if (d.temperature > thr_reflow) begin
					zone_entry(ZONE_HOLD, 1'b0, '0);
					restart = 1'b1;
				end else if (secs >= toggle_len) begin
					relay   = !relay;
					ticks   = '0;
					secs    = '0;
					restart = 1'b1;
				end
			end
			ZONE_HOLD: begin
				if (secs >= hold_len) begin
					zone_entry(ZONE_COOL, 1'b0, LED_COOL);
					restart = 1'b1;
				end
			end
			ZONE_COOL: begin
				if (d.temperature < thr_cool) begin
					zone_entry(ZONE_IDLE, 1'b0, LED_DONE);
					done    = 1'b1;
					restart = 1'b1;
				end
			end
			default: begin
				z_now = ZONE_IDLE;
				if (rise) begin
					leds = '0;
					zone_entry(ZONE_PREHEAT, 1'b1, LED_PREHEAT);
					restart = 1'b1;
				end
			end
		endcase
		// Prescale ticks into seconds in the timed zones; clamp the prescale
		// to 1..64 and saturate the seconds count
		if (!restart && z_now >= ZONE_PREHEAT && z_now <= ZONE_HOLD) begin
			top = (tps_reg == '0) ? 1 : (tps_reg > TPS_MAX) ? int'(TPS_MAX) : int'(tps_reg);
			if (int'(ticks) >= top - 1) begin
				ticks = '0;
				if (secs != SECONDS_MAX)
					secs = secs + 1'b1;
			end else begin
				ticks = ticks + 1'b1;
			end
		end
		sw_prev        = d.start_switch;
		r.heater_relay = relay;
		r.zone_leds    = leds;
		r.zone         = z_now;
		r.profile_done = done;
		return r;
	endfunction

	function automatic int pause_len();
		if (burst)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	function automatic logic [TEMP_BITS-1:0] above(input logic [TEMP_BITS-1:0] t);
		if (t == TEMP_TOP)
			return TEMP_TOP;
		return TEMP_BITS'($urandom_range(int'(t) + 1, int'(TEMP_TOP)));
	endfunction

	// Pick a tick that mostly follows a plausible oven curve for the zone
	// the model is in, with some noise and extremes mixed in
	function automatic rps_in_t next_sample();
		rps_in_t s;
		int      roll;
		roll = $urandom_range(0, 19);
		if (z_now == ZONE_IDLE)
			s.start_switch = ($urandom_range(0, 3) == 0) ? !sw_prev : sw_prev;
		else
			s.start_switch = ($urandom_range(0, 7) == 0) ? !sw_prev : sw_prev;
		if (roll < 2) begin
			s.temperature = TEMP_BITS'($urandom_range(0, int'(TEMP_TOP)));
		end else if (roll == 2) begin
			s.temperature = $urandom_range(0, 1) ? TEMP_TOP : '0;
		end else begin
			case (z_now)
				ZONE_PREHEAT: s.temperature = (roll < 5) ? above(thr_preheat)
					: TEMP_BITS'($urandom_range(0, int'(thr_preheat)));
				ZONE_REFLOW:  s.temperature = (roll < 5) ? above(thr_reflow)
					: TEMP_BITS'($urandom_range(0, int'(thr_reflow)));
				ZONE_COOL: begin
					if (roll < 6 && thr_cool != '0)
						s.temperature = TEMP_BITS'($urandom_range(0, int'(thr_cool) - 1));
					else
						s.temperature = TEMP_BITS'($urandom_range(int'(thr_cool),
							int'(TEMP_TOP)));
				end
				default: s.temperature = TEMP_BITS'($urandom_range(0, int'(TEMP_TOP)));
			endcase
		end
		return s;
	endfunction

	// Offer one tick beat after a random gap, hold it until taken, then
	// queue the status it should produce
	task automatic send_tick(input rps_in_t d, input logic typed, input rps_out_t want);
		int       gap;
		rps_out_t calc;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do
			@(posedge clk);
		while (in_stall);
		calc = oven_step(d);
		due_status.push_back(typed ? want : calc);
		@(negedge clk);
	endtask

	// Drop valid and wait until every queued status has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (due_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_PREHEAT_THR: thr_preheat = val[TEMP_BITS-1:0];
			CFG_SOAK_SECS:   soak_len    = val[SECONDS_BITS-1:0];
			CFG_REFLOW_THR:  thr_reflow  = val[TEMP_BITS-1:0];
			CFG_HOLD_SECS:   hold_len    = val[SECONDS_BITS-1:0];
			CFG_COOL_THR:    thr_cool    = val[TEMP_BITS-1:0];
			CFG_TOGGLE_SECS: toggle_len  = val[SECONDS_BITS-1:0];
			CFG_TICKS_PER_S: tps_reg     = val[TPS_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_profile(input int p);
		write_reg(CFG_PREHEAT_THR, PROFILES[p][0]);
		write_reg(CFG_SOAK_SECS,   PROFILES[p][1]);
		write_reg(CFG_REFLOW_THR,  PROFILES[p][2]);
		write_reg(CFG_HOLD_SECS,   PROFILES[p][3]);
		write_reg(CFG_COOL_THR,    PROFILES[p][4]);
		write_reg(CFG_TOGGLE_SECS, PROFILES[p][5]);
		write_reg(CFG_TICKS_PER_S, PROFILES[p][6]);
		cfg_we <= 1'b0;
	endtask

	// Sender: reset, directed table, then the random phases
	initial begin : stimulus
		int      k;
		int      p;
		rps_in_t d;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (k = 0; k < DIR_ROWS; k++) begin
			if (DIR_TAB[k].reconf) begin
				settle();
				apply_profile(0);
			end
			d.temperature  = DIR_TAB[k].temp;
			d.start_switch = DIR_TAB[k].sw;
			send_tick(d, DIR_TAB[k].typed, DIR_TAB[k].want);
		end
		for (p = 1; p < PHASES; p++) begin
			settle();
			apply_profile(p);
			for (k = 0; k < PHASE_ITEMS[p]; k++) begin
				if ($urandom_range(0, 39) == 0)
					burst = !burst;
				// Hold the receiver off while beats keep coming
				if (p == CHOKE_PHASE && k == 30) begin
					choke = 60;
					burst = 1'b1;
				end
				send_tick(next_sample(), 1'b0, NO_WANT);
			end
		end
		settle();
		repeat (10) @(negedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Receiver: stall a random number of cycles before each result beat, or for the choke length when one is set
	initial begin : status_sink
		int n;
		forever begin
			@(negedge clk);
			if (choke > 0) begin
				n     = choke;
				choke = 0;
			end else begin
				n = pause_len();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
		end
	end

	// Compare each taken result beat with the oldest queued status
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_status.size() == 0) begin
				$error("result beat with no status due: %p", out_data);
				fails++;
			end else begin
				oldest = due_status.pop_front();
				if (out_data.heater_relay !== oldest.heater_relay) begin
					$error("heater_relay: expected %0d, got %0d",
						oldest.heater_relay, out_data.heater_relay);
					fails++;
				end
				if (out_data.zone_leds !== oldest.zone_leds) begin
					$error("zone_leds: expected %b, got %b", oldest.zone_leds, out_data.zone_leds);
					fails++;
				end
				if (out_data.zone !== oldest.zone) begin
					$error("zone: expected %0d, got %0d", oldest.zone, out_data.zone);
					fails++;
				end
				if (out_data.profile_done !== oldest.profile_done) begin
					$error("profile_done: expected %0d, got %0d",
						oldest.profile_done, out_data.profile_done);
					fails++;
				end
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule
